// ===== src/mme_pkg.sv =====
// mme_pkg: shared types and constants of the matrix multiply engine
// no dependencies; imported by every module of the block

package mme_pkg;

  localparam int unsigned IDX_W       = 3;
  localparam int unsigned DIM_W       = 4;
  localparam int unsigned ELEM_IN_W   = 16;
  localparam int unsigned SUM_W       = 36;
  localparam int unsigned QUEUE_DEPTH = 2;

  // command codes of an input word
  typedef enum logic [1:0] {
    CMD_WR_LEFT  = 2'd0,
    CMD_WR_RIGHT = 2'd1,
    CMD_COMPUTE  = 2'd2
  } cmd_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_NUM_ROWS  = 2'd0,
    CFG_INNER_LEN = 2'd1,
    CFG_NUM_COLS  = 2'd2
  } cfg_idx_e;

  // operations that the back end carries out
  typedef enum logic [1:0] {
    OP_WR_LEFT,
    OP_WR_RIGHT,
    OP_COMPUTE
  } op_e;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_e;

  // queued operation, element value travels beside it
  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } qctl_t;

  // clamped dimensions, held as last index
  typedef struct packed {
    logic [IDX_W-1:0] rows_last;
    logic [IDX_W-1:0] inner_last;
    logic [IDX_W-1:0] cols_last;
  } dims_t;

  // tag that follows one product down the multiply pipeline
  typedef struct packed {
    logic             first;
    logic             last_k;
    logic             last_elem;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } tag_t;

endpackage

// ===== src/mme_front.sv =====
// mme_front: accepts input words, classifies them and pushes work to the queue
// depends on mme_pkg

module mme_front #(
  parameter int unsigned MAX_DIM      = 8,
  parameter int unsigned ELEMENT_BITS = 16
) (
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         cmd_i,
  input  logic [mme_pkg::IDX_W-1:0]          row_index_i,
  input  logic [mme_pkg::IDX_W-1:0]          col_index_i,
  input  logic signed [mme_pkg::ELEM_IN_W-1:0] elem_value_i,
  input  logic                               q_full_i,
  output logic                               q_push_o,
  output mme_pkg::qctl_t                     q_ctl_o,
  output logic [ELEMENT_BITS-1:0]            q_val_o
);
  import mme_pkg::*;

  logic in_range;
  logic useful;

  assign in_range = ({1'b0, row_index_i} < DIM_W'(MAX_DIM)) &&
                    ({1'b0, col_index_i} < DIM_W'(MAX_DIM));

  always_comb begin
    useful       = 1'b0;
    q_ctl_o.op   = OP_COMPUTE;
    q_ctl_o.row  = row_index_i;
    q_ctl_o.col  = col_index_i;
    case (cmd_i)
      CMD_WR_LEFT: begin
        useful     = in_range;
        q_ctl_o.op = OP_WR_LEFT;
      end
      CMD_WR_RIGHT: begin
        useful     = in_range;
        q_ctl_o.op = OP_WR_RIGHT;
      end
      CMD_COMPUTE: begin
        useful     = 1'b1;
        q_ctl_o.op = OP_COMPUTE;
      end
      default: begin
        useful = 1'b0;
      end
    endcase
  end

  // sign-extend or wrap to the stored element width
  assign q_val_o     = ELEMENT_BITS'(elem_value_i);

  // dropped words are taken without a push
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && useful;

endmodule

// ===== src/mme_queue.sv =====
// mme_queue: short fifo of operations between front and back end
// depends on mme_pkg

module mme_queue #(
  parameter int unsigned ELEMENT_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  mme_pkg::qctl_t          ctl_i,
  input  logic [ELEMENT_BITS-1:0] val_i,
  output logic                    full_o,
  output logic                    vld_o,
  output mme_pkg::qctl_t          ctl_o,
  output logic [ELEMENT_BITS-1:0] val_o,
  input  logic                    pop_i
);
  import mme_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  qctl_t                   ctl_mem [QUEUE_DEPTH];
  logic [ELEMENT_BITS-1:0] val_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    do_pop;

  assign full_o = (count_q == CNT_W'(QUEUE_DEPTH));
  assign vld_o  = (count_q != '0);
  assign do_pop = pop_i && vld_o;
  assign ctl_o  = ctl_mem[rd_ptr_q];
  assign val_o  = val_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ctl_mem[wr_ptr_q] <= ctl_i;
      val_mem[wr_ptr_q] <= val_i;
    end
  end

endmodule

// ===== src/mme_back.sv =====
// mme_back: element stores, sequencer and multiply-accumulate pipeline
// depends on mme_pkg

module mme_back #(
  parameter int unsigned MAX_DIM      = 8,
  parameter int unsigned ELEMENT_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  mme_pkg::dims_t                       dims_i,
  input  logic                                 q_vld_i,
  input  mme_pkg::qctl_t                       q_ctl_i,
  input  logic [ELEMENT_BITS-1:0]              q_val_i,
  output logic                                 q_pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [mme_pkg::IDX_W-1:0]            out_row_o,
  output logic [mme_pkg::IDX_W-1:0]            out_col_o,
  output logic signed [mme_pkg::SUM_W-1:0]     dot_sum_o,
  output logic                                 last_o
);
  import mme_pkg::*;

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [ELEMENT_BITS-1:0] left_mem  [DEPTH];
  logic [ELEMENT_BITS-1:0] right_mem [DEPTH];

  back_state_e state_q, state_d;

  logic [IDX_W-1:0] r_q, r_d, c_q, c_d, k_q, k_d;

  logic pop, wr_left, wr_right, start, issue, hold;
  logic k_end, c_end, r_end;
  logic [AW-1:0] wr_addr, a_addr, b_addr;

  logic                           s1_vld_q, s2_vld_q;
  tag_t                           s1_tag_q, s2_tag_q, issue_tag;
  logic signed [ELEMENT_BITS-1:0] a_rd_q, b_rd_q;
  logic signed [2*ELEMENT_BITS-1:0] prod_q;
  logic signed [SUM_W-1:0]        prod_ext, sum_next, acc_q;
  logic                           out_valid_q;

  assign k_end = (k_q == dims_i.inner_last);
  assign c_end = (c_q == dims_i.cols_last);
  assign r_end = (r_q == dims_i.rows_last);
  assign hold  = out_valid_q && out_stall_i;

  // outputs of the sequencer
  always_comb begin
    pop      = (state_q == BK_IDLE) && q_vld_i;
    wr_left  = pop && (q_ctl_i.op == OP_WR_LEFT);
    wr_right = pop && (q_ctl_i.op == OP_WR_RIGHT);
    start    = pop && (q_ctl_i.op == OP_COMPUTE);
    issue    = (state_q == BK_RUN) && !hold;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (start) begin
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        if (issue && k_end && c_end && r_end) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // k innermost, then column, then row
  always_comb begin
    r_d = r_q;
    c_d = c_q;
    k_d = k_q;
    if (start) begin
      r_d = '0;
      c_d = '0;
      k_d = '0;
    end else if (issue) begin
      if (!k_end) begin
        k_d = k_q + IDX_W'(1);
      end else begin
        k_d = '0;
        if (!c_end) begin
          c_d = c_q + IDX_W'(1);
        end else begin
          c_d = '0;
          r_d = r_q + IDX_W'(1);
        end
      end
    end
  end

  assign q_pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      r_q     <= '0;
      c_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      r_q     <= r_d;
      c_q     <= c_d;
      k_q     <= k_d;
    end
  end

  assign wr_addr = AW'(q_ctl_i.row * MAX_DIM + q_ctl_i.col);
  assign a_addr  = AW'(r_q * MAX_DIM + k_q);
  assign b_addr  = AW'(k_q * MAX_DIM + c_q);

  always_ff @(posedge clk_i) begin
    if (wr_left) begin
      left_mem[wr_addr] <= q_val_i;
    end
    if (issue) begin
      a_rd_q <= left_mem[a_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_right) begin
      right_mem[wr_addr] <= q_val_i;
    end
    if (issue) begin
      b_rd_q <= right_mem[b_addr];
    end
  end

  always_comb begin
    issue_tag.first     = (k_q == '0);
    issue_tag.last_k    = k_end;
    issue_tag.last_elem = k_end && c_end && r_end;
    issue_tag.row       = r_q;
    issue_tag.col       = c_q;
  end

  // pipeline valid bits, frozen while the result register is stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else if (!hold) begin
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_tag_q <= issue_tag;
    end
    if (!hold) begin
      s2_tag_q <= s1_tag_q;
      prod_q   <= a_rd_q * b_rd_q;
    end
  end

  assign prod_ext = SUM_W'(prod_q);
  assign sum_next = s2_tag_q.first ? prod_ext : acc_q + prod_ext;

  always_ff @(posedge clk_i) begin
    if (!hold && s2_vld_q) begin
      acc_q <= sum_next;
    end
    if (!hold && s2_vld_q && s2_tag_q.last_k) begin
      dot_sum_o <= sum_next;
      out_row_o <= s2_tag_q.row;
      out_col_o <= s2_tag_q.col;
      last_o    <= s2_tag_q.last_elem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!hold && s2_vld_q && s2_tag_q.last_k) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== src/matrix_multiply_engine_core.sv =====
// matrix_multiply_engine_core: fixed-point matrix multiply C = A x B, signed Q8.8 in
// element write: the back end pops it from the queue and writes its store only while idle
// compute: one result word per dot product, each summed in turn by the single
// multiply-accumulate unit; a stalled result word freezes the pipeline
// reset: config registers to 8, queue and pipeline empty; element stores are not cleared
// depends on mme_pkg, mme_front, mme_queue, mme_back

module matrix_multiply_engine_core #(
  parameter int unsigned MAX_DIM      = 8,
  parameter int unsigned ELEMENT_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input word channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           cmd_i,
  input  logic [mme_pkg::IDX_W-1:0]            row_index_i,
  input  logic [mme_pkg::IDX_W-1:0]            col_index_i,
  input  logic signed [mme_pkg::ELEM_IN_W-1:0] elem_value_i,
  // result word channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [mme_pkg::IDX_W-1:0]            out_row_o,
  output logic [mme_pkg::IDX_W-1:0]            out_col_o,
  output logic signed [mme_pkg::SUM_W-1:0]     dot_sum_o,
  output logic                                 last_o,
  // configuration write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [1:0]                           cfg_index_i,
  input  logic [mme_pkg::DIM_W-1:0]            cfg_data_i
);
  import mme_pkg::*;

  // raw register bits are kept as written; clamping happens on use
  logic [DIM_W-1:0] num_rows_q, inner_len_q, num_cols_q;
  dims_t            dims;

  // front to queue
  logic                    q_push, q_full;
  qctl_t                   push_ctl;
  logic [ELEMENT_BITS-1:0] push_val;

  // queue to back
  logic                    q_vld, q_pop;
  qctl_t                   head_ctl;
  logic [ELEMENT_BITS-1:0] head_val;

  // zero counts as one, anything above the maximum as the maximum
  function automatic logic [IDX_W-1:0] last_idx(input logic [DIM_W-1:0] v);
    logic [IDX_W-1:0] res;
    if (v == '0) begin
      res = '0;
    end else if (v > DIM_W'(MAX_DIM)) begin
      res = IDX_W'(MAX_DIM - 1);
    end else begin
      res = IDX_W'(v - DIM_W'(1));
    end
    return res;
  endfunction

  // configuration port never pushes back
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q  <= DIM_W'(8);
      inner_len_q <= DIM_W'(8);
      num_cols_q  <= DIM_W'(8);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_NUM_ROWS:  num_rows_q  <= cfg_data_i;
        CFG_INNER_LEN: inner_len_q <= cfg_data_i;
        CFG_NUM_COLS:  num_cols_q  <= cfg_data_i;
        default: begin
          // index beyond the register list is dropped
        end
      endcase
    end
  end

  always_comb begin
    dims.rows_last  = last_idx(num_rows_q);
    dims.inner_last = last_idx(inner_len_q);
    dims.cols_last  = last_idx(num_cols_q);
  end

  // front end: takes every word unless the queue is full, forwards only those with work to do
  mme_front #(
    .MAX_DIM      (MAX_DIM),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .row_index_i  (row_index_i),
    .col_index_i  (col_index_i),
    .elem_value_i (elem_value_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_ctl_o      (push_ctl),
    .q_val_o      (push_val)
  );

  // decoupling queue so the front keeps accepting while a compute runs, until the queue is full
  mme_queue #(
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .ctl_i  (push_ctl),
    .val_i  (push_val),
    .full_o (q_full),
    .vld_o  (q_vld),
    .ctl_o  (head_ctl),
    .val_o  (head_val),
    .pop_i  (q_pop)
  );

  // back end: stores plus read / multiply / accumulate pipeline
  mme_back #(
    .MAX_DIM      (MAX_DIM),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dims_i      (dims),
    .q_vld_i     (q_vld),
    .q_ctl_i     (head_ctl),
    .q_val_i     (head_val),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .dot_sum_o   (dot_sum_o),
    .last_o      (last_o)
  );

  // the front never pushes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_push && q_full))
    else $error("push into full queue");

  // every result lies inside the configured result shape
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_row_o <= dims.rows_last) && (out_col_o <= dims.cols_last))
    else $error("result index outside configured shape");

  // last flag only on the bottom-right element
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |->
      (out_row_o == dims.rows_last) && (out_col_o == dims.cols_last))
    else $error("last flag on wrong element");

endmodule
